[design/assert_macros.svh]
// Assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_AT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("assert failed");
`define ASSERT_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error("never failed");
`else
`define ASSERT_AT(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, expr)
`endif
`endif

[design/tss_pkg.sv]
package tss_pkg;
  localparam int SampleBits = 12;
  localparam int StampBits  = 32;
  localparam int AccBits    = 64;
  localparam int DivBits    = StampBits + 1;
  localparam int SqBits     = 2 * SampleBits;

  localparam logic [1:0] StatusOk    = 2'd0;
  localparam logic [1:0] StatusShort = 2'd1;
  localparam logic [1:0] StatusZero  = 2'd2;

  localparam logic signed [SampleBits-1:0] SMax = {1'b0, {(SampleBits-1){1'b1}}};
  localparam logic signed [SampleBits-1:0] SMin = {1'b1, {(SampleBits-1){1'b0}}};

  typedef struct packed {
    logic clear;
    logic accum;
    logic mul_go;
    logic fin_start;
    logic div_step;
    logic sqrt_step;
    logic finish;
  } tss_cmd_t;

  typedef struct packed {
    logic short_rec;
    logic zero_dur;
  } tss_stat_t;
endpackage

[design/tss_datapath.sv]
`include "assert_macros.svh"
module tss_datapath import tss_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  tss_cmd_t                     cmd_i,
  input  logic [StampBits-1:0]         time_i,
  input  logic signed [SampleBits-1:0] value_i,
  output tss_stat_t                    stat_o,
  output logic [5*SampleBits:0]        res_o
);
  logic [StampBits-1:0] first_q, prev_t_q, dt_q;
  logic signed [SampleBits-1:0] prev_v_q, min_q, max_q;
  logic signed [AccBits-1:0] lin_q;
  logic [AccBits-1:0] sq_q;
  logic [1:0] seen_q;
  logic signed [SampleBits:0] vsum_q;
  logic [SqBits:0] sqsum_q;
  logic signed [SampleBits+StampBits+1:0] linp_q;
  logic [SqBits+StampBits+1:0] sqp_q;
  logic [StampBits-1:0] dur_q;
  // division: restoring, one counter and divisor shared by both sums
  logic [AccBits-1:0] num_lin_q, rem_lin_q, num_sq_q, rem_sq_q;
  logic lin_neg_q;
  logic [6:0] cnt_q;
  logic [AccBits-1:0] rx_q, rroot_q, rbit_q;
  logic [1:0] status_q;
  logic signed [SampleBits-1:0] mean_q;
  logic [SampleBits-1:0] rms_sat;

  logic signed [SqBits-1:0] sq_prev, sq_cur;
  assign sq_prev = SqBits'(prev_v_q) * SqBits'(prev_v_q);
  assign sq_cur = SqBits'(value_i) * SqBits'(value_i);

  logic [DivBits-1:0] d2;
  assign d2 = {dur_q, 1'b0};

  logic [AccBits:0] rl_sh, rs_sh;
  assign rl_sh = {rem_lin_q, num_lin_q[AccBits-1]};
  assign rs_sh = {rem_sq_q, num_sq_q[AccBits-1]};

  logic signed [AccBits-1:0] lin_ext;
  logic signed [AccBits:0] lin_sum;
  assign lin_ext = AccBits'(linp_q);
  assign lin_sum = {lin_q[AccBits-1], lin_q} + {lin_ext[AccBits-1], lin_ext};
  logic [AccBits:0] sq_sum;
  assign sq_sum = {1'b0, sq_q} + {1'b0, AccBits'(sqp_q)};

  logic [AccBits-1:0] lin_abs;
  assign lin_abs = lin_q[AccBits-1] ? AccBits'(-lin_q) : lin_q;

  logic [AccBits-1:0] rtry;
  assign rtry = rroot_q + rbit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= '0; prev_t_q <= '0; prev_v_q <= '0;
      min_q <= SMax; max_q <= SMin; lin_q <= '0; sq_q <= '0; seen_q <= '0;
      cnt_q <= '0; status_q <= StatusOk;
      dt_q <= '0; vsum_q <= '0; sqsum_q <= '0; linp_q <= '0; sqp_q <= '0; dur_q <= '0;
      num_lin_q <= '0; rem_lin_q <= '0; num_sq_q <= '0; rem_sq_q <= '0;
      lin_neg_q <= 1'b0; rx_q <= '0; rroot_q <= '0; rbit_q <= '0; mean_q <= '0;
    end else begin
      if (cmd_i.accum) begin
        // no step on the first sample of a record
        dt_q <= (seen_q == 2'd0) ? '0 : time_i - prev_t_q;
        vsum_q <= (SampleBits+1)'(prev_v_q) + (SampleBits+1)'(value_i);
        sqsum_q <= (SqBits+1)'($unsigned(sq_prev)) + (SqBits+1)'($unsigned(sq_cur));
        if (seen_q == 2'd0) first_q <= time_i;
        dur_q <= time_i - ((seen_q == 2'd0) ? time_i : first_q);
        if (value_i < min_q) min_q <= value_i;
        if (value_i > max_q) max_q <= value_i;
        prev_t_q <= time_i;
        prev_v_q <= value_i;
        if (seen_q != 2'd2) seen_q <= seen_q + 2'd1;
      end
      if (cmd_i.mul_go) begin
        linp_q <= vsum_q * $signed({1'b0, dt_q});
        sqp_q <= sqsum_q * dt_q;
      end
      if (cmd_i.fin_start) begin
        if (lin_sum[AccBits] != lin_sum[AccBits-1])
          lin_q <= lin_sum[AccBits] ? {1'b1, {(AccBits-1){1'b0}}} : {1'b0, {(AccBits-1){1'b1}}};
        else
          lin_q <= lin_sum[AccBits-1:0];
        sq_q <= sq_sum[AccBits] ? '1 : sq_sum[AccBits-1:0];
        status_q <= (seen_q != 2'd2) ? StatusShort : (dur_q == '0) ? StatusZero : StatusOk;
      end
      if (cmd_i.div_step && cnt_q == 7'd0) begin
        num_lin_q <= lin_abs; lin_neg_q <= lin_q[AccBits-1];
        num_sq_q <= sq_q; rem_lin_q <= '0; rem_sq_q <= '0;
        cnt_q <= 7'd1;
      end else if (cmd_i.div_step) begin
        num_lin_q <= {num_lin_q[AccBits-2:0], (rl_sh >= (AccBits+1)'(d2))};
        rem_lin_q <= (rl_sh >= (AccBits+1)'(d2)) ? AccBits'(rl_sh - (AccBits+1)'(d2))
                                                 : rl_sh[AccBits-1:0];
        num_sq_q <= {num_sq_q[AccBits-2:0], (rs_sh >= (AccBits+1)'(d2))};
        rem_sq_q <= (rs_sh >= (AccBits+1)'(d2)) ? AccBits'(rs_sh - (AccBits+1)'(d2))
                                                : rs_sh[AccBits-1:0];
        cnt_q <= (cnt_q == 7'd64) ? 7'd0 : cnt_q + 7'd1;
        if (cnt_q == 7'd64) begin
          rx_q <= {num_sq_q[AccBits-2:0], (rs_sh >= (AccBits+1)'(d2))};
          rroot_q <= '0;
          rbit_q <= {2'b01, {(AccBits-2){1'b0}}};
          if (lin_neg_q)
            mean_q <= ($unsigned({num_lin_q[AccBits-2:0], rl_sh >= (AccBits+1)'(d2)})
                       > AccBits'(2**(SampleBits-1))) ? SMin
                    : SampleBits'(-{num_lin_q[AccBits-2:0], rl_sh >= (AccBits+1)'(d2)});
          else
            mean_q <= ({num_lin_q[AccBits-2:0], rl_sh >= (AccBits+1)'(d2)}
                       > AccBits'(SMax)) ? SMax
                    : SampleBits'({num_lin_q[AccBits-2:0], rl_sh >= (AccBits+1)'(d2)});
        end
      end
      if (cmd_i.sqrt_step) begin
        if (rx_q >= rtry) begin
          rx_q <= rx_q - rtry;
          rroot_q <= (rroot_q >> 1) + rbit_q;
        end else begin
          rroot_q <= rroot_q >> 1;
        end
        rbit_q <= rbit_q >> 2;
      end
      if (cmd_i.clear) begin
        first_q <= '0; prev_t_q <= '0; prev_v_q <= '0;
        min_q <= SMax; max_q <= SMin; lin_q <= '0; sq_q <= '0; seen_q <= '0;
      end
    end
  end

  assign rms_sat = (rroot_q > AccBits'(2**(SampleBits-1))) ? SampleBits'(2**(SampleBits-1))
                 : SampleBits'(rroot_q);

  logic [SampleBits:0] swing;
  assign swing = (SampleBits+1)'(max_q) - (SampleBits+1)'(min_q);

  logic ok;
  assign ok = status_q == StatusOk;
  assign stat_o.short_rec = seen_q != 2'd2;
  assign stat_o.zero_dur = dur_q == '0;
  assign res_o = {status_q, ok ? rms_sat : '0, swing[SampleBits-1:1],
                  ok ? mean_q : '0, max_q, min_q};

  `ASSERT_AT(a_seen_max, clk_i, rst_ni, seen_q != 2'd3)
  `ASSERT_AT(a_cnt_rng, clk_i, rst_ni, cnt_q <= 7'd64)
  `ASSERT_NEVER(a_minmax, clk_i, rst_ni, seen_q != 2'd0 && min_q > max_q)
endmodule

[design/tss_ctrl.sv]
`include "assert_macros.svh"
module tss_ctrl import tss_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_last_i,
  input  tss_stat_t stat_i,
  input  logic      out_ready_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  output tss_cmd_t  cmd_o
);
  typedef enum logic [2:0] {Idle, Mul, Acc, Div, Sqrt, Done} state_e;
  state_e state_q;
  logic last_q, div_extra_q;
  logic [5:0] n_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= Idle; last_q <= 1'b0; n_q <= '0; div_extra_q <= 1'b0;
    end else begin
      div_extra_q <= (state_q == Div && n_q == 6'd63);
      case (state_q)
        Idle: if (in_valid_i) begin
          last_q <= in_last_i;
          state_q <= Mul;
        end
        Mul: state_q <= Acc;
        Acc: begin
          if (!last_q) state_q <= Idle;
          else if (stat_i.short_rec || stat_i.zero_dur) state_q <= Done;
          else state_q <= Div;
          n_q <= '0;
        end
        Div: begin
          n_q <= n_q + 6'd1;
          if (n_q == 6'd63) state_q <= Sqrt;
        end
        Sqrt: begin
          n_q <= n_q + 6'd1;
          if (n_q == 6'd32) state_q <= Done;
        end
        Done: if (out_ready_i) state_q <= Idle;
        default: state_q <= Idle;
      endcase
    end
  end

  assign in_ready_o = state_q == Idle;
  assign out_valid_o = state_q == Done;
  assign cmd_o.accum = state_q == Idle && in_valid_i;
  assign cmd_o.mul_go = state_q == Mul;
  // first sample of a record adds a zero-time product
  assign cmd_o.fin_start = state_q == Acc;
  assign cmd_o.div_step = state_q == Div || div_extra_q;
  assign cmd_o.sqrt_step = state_q == Sqrt && n_q != 6'd0 && n_q <= 6'd32;
  assign cmd_o.finish = out_valid_o && out_ready_i;
  assign cmd_o.clear = cmd_o.finish;

  `ASSERT_NEVER(a_busy_rdy, clk_i, rst_ni, in_ready_o && out_valid_o)
  `ASSERT_AT(a_acc_idle, clk_i, rst_ni, cmd_o.accum |=> state_q == Mul)
  `ASSERT_AT(a_done_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o)
endmodule

[design/trapezoid_signal_statistics.sv]
// Flow: a non-last word is multiplied and accumulated, then the input is free again;
// a last word is also divided and square-rooted before tvalid rises, or raises tvalid
// straight after accumulate when the record is short or has zero duration.
// Occupancy: one word in flight; the next word is taken only once the previous one
// is accumulated, and a record end also waits for divide, root and output stalls.
// Reset (rst_ni low, asynchronous) clears the record and all control state.
module trapezoid_signal_statistics import tss_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [47:0] s_axis_tdata_i, // sample_time[31:0], sample_value[43:32]
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // minimum, maximum, mean_value, half_swing, rms_value, status
  output logic [63:0] m_axis_tdata_o
);
  tss_cmd_t cmd;
  tss_stat_t stat;
  logic [5*SampleBits:0] res;

  tss_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid_i), .in_last_i(s_axis_tlast_i), .stat_i(stat),
    .out_ready_i(m_axis_tready_i), .in_ready_o(s_axis_tready_o),
    .out_valid_o(m_axis_tvalid_o), .cmd_o(cmd)
  );

  tss_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd),
    .time_i(s_axis_tdata_i[StampBits-1:0]),
    .value_i(s_axis_tdata_i[StampBits+SampleBits-1:StampBits]),
    .stat_o(stat), .res_o(res)
  );

  assign m_axis_tdata_o = {3'b0, res};
endmodule

[test/trapezoid_signal_statistics_tb.sv]
module trapezoid_signal_statistics_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tss_pkg::*;

  typedef struct packed {
    logic [1:0]             status;
    logic [11:0]            rms;
    logic [10:0]            half;
    logic signed [11:0]     mean;
    logic signed [11:0]     maxv;
    logic signed [11:0]     minv;
  } stats_t;

  typedef struct {
    logic [31:0]        stamp;
    logic signed [11:0] value;
    logic               last;
    logic               typed;
    stats_t             want;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [47:0] s_axis_tdata_i = '0;
  logic        s_axis_tlast_i = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [63:0] m_axis_tdata_o;

  trapezoid_signal_statistics u_top (.*);

  always #6 clk_i = ~clk_i;

  // record state of the predictor
  logic [31:0]        rec_first, rec_prev_t;
  logic signed [11:0] rec_prev_v, rec_lo, rec_hi;
  longint             lin_acc;
  logic [63:0]        sq_acc;
  int                 rec_seen;

  stats_t stats_q[$];
  int     errors = 0;
  int     words_in = 0;
  int     records = 0;
  int     results_seen = 0;
  int     burst_left = 0;

  row_t rows[24];
  int   n_rows = 0;

  function automatic void add_row(row_t r);
    rows[n_rows] = r;
    n_rows++;
  endfunction

  function automatic logic [63:0] isqrt(logic [63:0] x);
    logic [63:0] root, b;
    root = '0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= root + b) begin
        x = x - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return root;
  endfunction

  function automatic void clear_record();
    rec_first = '0;
    rec_prev_t = '0;
    rec_prev_v = '0;
    rec_lo = SMax;
    rec_hi = SMin;
    lin_acc = 0;
    sq_acc = '0;
    rec_seen = 0;
  endfunction

  // returns 1 and the statistics when the word closes a record
  function automatic bit track_sample(logic [31:0] t, logic signed [11:0] v, logic last,
                                      output stats_t r);
    logic [31:0] dt, dur;
    longint      lin, s, m, d2;
    logic [63:0] sq, q, rt;
    logic [64:0] usum;
    r = '0;
    if (rec_seen == 0) begin
      rec_first = t;
    end else begin
      dt = t - rec_prev_t;
      lin = (longint'(rec_prev_v) + longint'(v)) * longint'(dt);
      sq = (longint'(rec_prev_v) * longint'(rec_prev_v) + longint'(v) * longint'(v))
           * longint'(dt);
      s = lin_acc + lin;
      if (lin_acc > 0 && lin > 0 && s < 0) s = 64'sh7fff_ffff_ffff_ffff;
      if (lin_acc < 0 && lin < 0 && s >= 0) s = 64'sh8000_0000_0000_0000;
      lin_acc = s;
      usum = {1'b0, sq_acc} + {1'b0, sq};
      sq_acc = usum[64] ? '1 : usum[63:0];
    end
    if (v < rec_lo) rec_lo = v;
    if (v > rec_hi) rec_hi = v;
    rec_prev_t = t;
    rec_prev_v = v;
    if (rec_seen < 2) rec_seen++;
    if (!last) return 0;
    dur = t - rec_first;
    r.minv = rec_lo;
    r.maxv = rec_hi;
    r.half = 11'((int'(rec_hi) - int'(rec_lo)) >> 1);
    if (rec_seen < 2) begin
      r.status = StatusShort;
    end else if (dur == 0) begin
      r.status = StatusZero;
    end else begin
      r.status = StatusOk;
      d2 = longint'(dur) * 2;
      m = lin_acc / d2;
      if (m > 2047) m = 2047;
      if (m < -2048) m = -2048;
      r.mean = 12'(m);
      q = sq_acc / {31'b0, dur, 1'b0};
      rt = isqrt(q);
      if (rt > 2048) rt = 2048;
      r.rms = 12'(rt);
    end
    clear_record();
    return 1;
  endfunction

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0d want %0d (result %0d)", what, got, want, results_seen);
    errors++;
  endtask

  task automatic send_word(logic [31:0] t, logic signed [11:0] v, logic last,
                           logic typed = 1'b0, stats_t want = '0);
    stats_t r;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      if ($urandom_range(0, 3) != 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {4'b0, v, t};
    s_axis_tlast_i <= last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    words_in++;
    if (track_sample(t, v, last, r)) begin
      stats_q.insert(stats_q.size(), typed ? want : r);
      records++;
    end
  endtask

  // result checker
  always @(posedge clk_i) begin
    stats_t g, w;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      g = m_axis_tdata_o[60:0];
      results_seen++;
      if (stats_q.size() == 0) begin
        report("unexpected word", int'(m_axis_tdata_o[31:0]), 0);
      end else begin
        w = stats_q.pop_front();
        if (g.minv !== w.minv) report("minimum", g.minv, w.minv);
        if (g.maxv !== w.maxv) report("maximum", g.maxv, w.maxv);
        if (g.mean !== w.mean) report("mean_value", g.mean, w.mean);
        if (g.half !== w.half) report("half_swing", g.half, w.half);
        if (g.rms !== w.rms) report("rms_value", g.rms, w.rms);
        if (g.status !== w.status) report("status", g.status, w.status);
        if (m_axis_tdata_o[63:61] !== 3'b0) report("pad bits", m_axis_tdata_o[63:61], 0);
      end
    end
  end

  // receiver stall pattern: free-running, 50 percent, and long stalls in turn
  always @(posedge clk_i) begin
    int unsigned ph;
    ph = 32'(($time / 12 / 300) % 3);
    case (ph)
      0: m_axis_tready_i <= 1'b1;
      1: m_axis_tready_i <= 1'($urandom_range(0, 1));
      default: m_axis_tready_i <= ($urandom_range(0, 9) == 0);
    endcase
  end

  initial begin
    #20ms;
    $display("trapezoid_signal_statistics_tb: errors");
    $finish;
  end

  initial begin
    int len;
    logic [31:0] t;
    logic signed [11:0] v;
    clear_record();
    add_row('{100, 2047, 1, 1, '{StatusShort, 0, 0, 0, 2047, 2047}});
    add_row('{5, -2048, 1, 1, '{StatusShort, 0, 0, 0, -2048, -2048}});
    add_row('{7, 10, 0, 0, '0});
    add_row('{7, -10, 1, 1, '{StatusZero, 0, 10, 0, 10, -10}});
    add_row('{0, 2047, 0, 0, '0});
    add_row('{10, 2047, 1, 1, '{StatusOk, 2047, 0, 2047, 2047, 2047}});
    add_row('{32'hffff_fff0, -2048, 0, 0, '0});
    add_row('{32'hffff_fff4, -2048, 1, 1, '{StatusOk, 2048, 0, -2048, -2048, -2048}});
    add_row('{0, -2048, 0, 0, '0});
    add_row('{1, 2047, 1, 0, '0});
    // wrapped step: steps far exceed the duration, so mean and rms clamp
    add_row('{0, 2047, 0, 0, '0});
    add_row('{32'hffff_ffff, 2047, 0, 0, '0});
    add_row('{1, 2047, 1, 0, '0});
    add_row('{0, -2048, 0, 0, '0});
    add_row('{32'hffff_ffff, -2048, 0, 0, '0});
    add_row('{1, -2048, 1, 0, '0});
    add_row('{1000, 0, 0, 0, '0});
    add_row('{990, 5, 0, 0, '0});
    add_row('{1003, -7, 0, 0, '0});
    add_row('{1020, 1, 1, 0, '0});
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int i = 0; i < n_rows; i++)
      send_word(rows[i].stamp, rows[i].value, rows[i].last, rows[i].typed, rows[i].want);

    while (words_in < 1650) begin
      if (words_in > 800 && words_in < 815) begin
        s_axis_tvalid_i <= 1'b0;
        while (stats_q.size() != 0) @(posedge clk_i);
        repeat (120) @(posedge clk_i);
      end
      len = ($urandom_range(0, 19) == 0) ? 1 : $urandom_range(2, 12);
      t = $urandom;
      for (int k = 0; k < len; k++) begin
        case ($urandom_range(0, 9))
          0: v = SMax;
          1: v = SMin;
          default: v = 12'($urandom);
        endcase
        send_word(t, v, k == len - 1);
        case ($urandom_range(0, 39))
          0: t = $urandom;
          1, 2: t = t;
          default: t = t + $urandom_range(1, 300);
        endcase
      end
    end
    s_axis_tvalid_i <= 1'b0;
    while (stats_q.size() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
    $display("covered %0d words in %0d records, %0d results checked", words_in, records,
             results_seen);
    $display("records include single-sample, zero-duration and wrapped-stamp cases");
    if (errors == 0) begin
      $display("trapezoid_signal_statistics_tb: clean");
    end else begin
      $display("trapezoid_signal_statistics_tb: errors");
    end
    $finish;
  end
endmodule
